[rtl/core/lobm_pkg.sv]
// lobm_pkg: word types and codes for the order book matcher
// no dependencies
package lobm_pkg;

	localparam int RCAP = 64;
	localparam int RAW = 6;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_CANCEL = 1'b1;

	localparam logic SIDE_BUY = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_RESTED = 3'd0;
	localparam logic [2:0] ST_DONE = 3'd1;
	localparam logic [2:0] ST_CANCELLED = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_POOLFULL = 3'd4;

	typedef struct packed {
		logic mode;
		logic [31:0] order_id;
		logic side;
		logic [7:0] price_tick;
		logic [31:0] quantity;
	} in_word_t;

	typedef struct packed {
		logic is_trade;
		logic [31:0] resting_order_id;
		logic [31:0] aggressor_order_id;
		logic [7:0] trade_price_tick;
		logic [31:0] fill_quantity;
		logic last;
		logic [2:0] status;
		logic [7:0] best_bid_tick;
		logic bid_present;
		logic [7:0] best_ask_tick;
		logic ask_present;
	} out_word_t;

	typedef struct packed {
		logic [31:0] rid;
		logic [7:0] price;
		logic [31:0] fill;
	} trade_t;

endpackage

[rtl/core/limit_order_book_matcher_top.sv]
// limit_order_book_matcher_top: price-time priority matcher on node and level memories
// depends on lobm_pkg
//
// channel  signals                      dir  word
// ord      ord_valid ord_ready ord      in   lobm_pkg::in_word_t
// res      res_valid res_ready res      out  lobm_pkg::out_word_t
//
// one word in per step; a step emits one word per fill or one status word
// add: each fill reads the level and its head node; resting writes the node and level, plus
//   a level rescan in chunks of 16 levels each time a price level empties
// cancel: searches the pool entries in order (up to MAX_ORDERS), then unlinks the node
// results leave one per cycle from the trade buffer while res_ready is high
// reset clears the book at once; no clearing pass
module limit_order_book_matcher_top #(
	parameter int MAX_ORDERS = 64,
	parameter int PRICE_LEVELS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic ord_valid,
	output logic ord_ready,
	input lobm_pkg::in_word_t ord,
	output logic res_valid,
	input logic res_ready,
	output lobm_pkg::out_word_t res
);
	import lobm_pkg::*;

	localparam int NW = $clog2(MAX_ORDERS + 1);
	localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam int PW = $clog2(PRICE_LEVELS);
	localparam int NCH = (PRICE_LEVELS + 15) / 16;
	localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam logic [NW-1:0] NIL = NW'(MAX_ORDERS);

	typedef struct packed {
		logic [31:0] oid;
		logic [31:0] qty;
		logic [NW-1:0] next;
		logic [NW-1:0] prev;
		logic side;
		logic [PW-1:0] price;
	} node_t;

	typedef struct packed {
		logic [NW-1:0] head;
		logic [NW-1:0] tail;
	} level_t;

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_MCHK = 17'h00002,
		S_MLVL = 17'h00004,
		S_MNODE = 17'h00008,
		S_MNXW = 17'h00010,
		S_REST = 17'h00020,
		S_AREAD = 17'h00040,
		S_PLVL = 17'h00080,
		S_PTW = 17'h00100,
		S_CRD = 17'h00200,
		S_CCMP = 17'h00400,
		S_CLVL = 17'h00800,
		S_CPW = 17'h01000,
		S_CNW = 17'h02000,
		S_SCAN = 17'h04000,
		S_OUT = 17'h08000,
		S_OLOAD = 17'h10000
	} state_t;

	node_t nmem [MAX_ORDERS];
	level_t lmem [2**(PW+1)];
	trade_t rmem [RCAP];

	node_t nrd, n_wd;
	level_t lrd, l_wd;
	trade_t rrd, r_wd;
	logic n_we, n_re, l_we, l_re, r_we, r_re;
	logic [IW-1:0] n_wa, n_ra;
	logic [PW:0] l_wa, l_ra;
	logic [RAW-1:0] r_wa, r_ra;

	state_t state_q, state_d, scret_q, scret_d;
	logic [31:0] id_q, id_d, rem_q, rem_d;
	logic side_q, side_d;
	logic [PW-1:0] price_q, price_d, lvl_q, lvl_d;
	logic [6:0] n_q, n_d, oj_q, oj_d;
	logic [2:0] status_q, status_d;
	logic [PW-1:0] bbid_q, bbid_d, bask_q, bask_d;
	logic bid_ok_q, bid_ok_d, ask_ok_q, ask_ok_d;
	logic [NW-1:0] fh_q, fh_d, used_q, used_d, aidx_q, aidx_d;
	logic [NW-1:0] nx_q, nx_d, pv_q, pv_d;
	logic [MAX_ORDERS-1:0] live_q, live_d;
	logic [1:0][PRICE_LEVELS-1:0] bmp_q, bmp_d;
	logic [IW-1:0] ci_q, ci_d;
	logic cside_q, cside_d;
	logic [PW-1:0] cprice_q, cprice_d;
	logic [CW-1:0] sc_q, sc_d;
	logic scside_q, scside_d;
	out_word_t res_q, res_d;
	logic res_valid_q, out_ld, slot_free;

	logic [12:0] price_ext, price_sat;
	logic [PW-1:0] m_lvl;
	logic m_cross;
	logic [31:0] m_fill;
	logic [NCH*16-1:0] scan_pad;
	logic [15:0] chunk;
	logic [3:0] lo_bit, hi_bit;
	logic tv;

	assign price_ext = 13'(ord.price_tick);
	assign price_sat = (price_ext >= 13'(PRICE_LEVELS)) ? 13'(PRICE_LEVELS - 1) : price_ext;
	assign m_lvl = side_q ? bbid_q : bask_q;
	assign m_cross = side_q ? (bid_ok_q && bbid_q >= price_q) : (ask_ok_q && bask_q <= price_q);
	assign m_fill = (rem_q < nrd.qty) ? rem_q : nrd.qty;
	assign scan_pad = (NCH*16)'(bmp_q[scside_q]);
	assign chunk = scan_pad[{sc_q, 4'b0000} +: 16];
	assign tv = bmp_q[side_q][price_q];
	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		lo_bit = 4'd0;
		hi_bit = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (chunk[k]) begin
				lo_bit = 4'(k);
			end
		end
		for (int k = 0; k < 16; k++) begin
			if (chunk[k]) begin
				hi_bit = 4'(k);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		scret_d = scret_q;
		id_d = id_q;
		rem_d = rem_q;
		side_d = side_q;
		price_d = price_q;
		lvl_d = lvl_q;
		n_d = n_q;
		oj_d = oj_q;
		status_d = status_q;
		bbid_d = bbid_q;
		bask_d = bask_q;
		bid_ok_d = bid_ok_q;
		ask_ok_d = ask_ok_q;
		fh_d = fh_q;
		used_d = used_q;
		aidx_d = aidx_q;
		nx_d = nx_q;
		pv_d = pv_q;
		live_d = live_q;
		bmp_d = bmp_q;
		ci_d = ci_q;
		cside_d = cside_q;
		cprice_d = cprice_q;
		sc_d = sc_q;
		scside_d = scside_q;
		n_we = 1'b0;
		n_wa = '0;
		n_wd = nrd;
		n_re = 1'b0;
		n_ra = '0;
		l_we = 1'b0;
		l_wa = '0;
		l_wd = lrd;
		l_re = 1'b0;
		l_ra = '0;
		r_we = 1'b0;
		r_wa = n_q[RAW-1:0];
		r_wd = '0;
		r_re = 1'b0;
		r_ra = '0;
		out_ld = 1'b0;
		res_d = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (ord_valid) begin
					id_d = ord.order_id;
					side_d = ord.side;
					price_d = PW'(price_sat);
					rem_d = ord.quantity;
					n_d = '0;
					ci_d = '0;
					if (ord.mode == MODE_CANCEL) begin
						status_d = ST_NOTFOUND;
						state_d = S_CRD;
					end else if (ord.quantity == '0) begin
						status_d = ST_DONE;
						state_d = S_OUT;
					end else begin
						state_d = S_MCHK;
					end
				end
			end
			S_MCHK: begin
				if (rem_q != '0 && n_q < 7'(RCAP) && m_cross) begin
					lvl_d = m_lvl;
					l_re = 1'b1;
					l_ra = {~side_q, m_lvl};
					state_d = S_MLVL;
				end else begin
					state_d = S_REST;
				end
			end
			S_MLVL: begin
				n_re = 1'b1;
				n_ra = IW'(lrd.head);
				state_d = S_MNODE;
			end
			S_MNODE: begin
				r_we = 1'b1;
				r_wd = '{rid: nrd.oid, price: 8'(lvl_q), fill: m_fill};
				n_d = n_q + 7'd1;
				rem_d = rem_q - m_fill;
				n_we = 1'b1;
				n_wa = IW'(lrd.head);
				if (nrd.qty != m_fill) begin
					n_wd.qty = nrd.qty - m_fill;
					state_d = S_MCHK;
				end else begin
					n_wd.next = fh_q;
					fh_d = lrd.head;
					live_d[IW'(lrd.head)] = 1'b0;
					nx_d = nrd.next;
					l_we = 1'b1;
					l_wa = {~side_q, lvl_q};
					l_wd.head = nrd.next;
					l_wd.tail = (nrd.next < NIL) ? lrd.tail : NIL;
					if (nrd.next < NIL) begin
						n_re = 1'b1;
						n_ra = IW'(nrd.next);
						state_d = S_MNXW;
					end else begin
						bmp_d[~side_q][lvl_q] = 1'b0;
						scside_d = ~side_q;
						sc_d = side_q ? CW'(NCH - 1) : '0;
						scret_d = S_MCHK;
						state_d = S_SCAN;
					end
				end
			end
			S_MNXW: begin
				n_we = 1'b1;
				n_wa = IW'(nx_q);
				n_wd.prev = NIL;
				state_d = S_MCHK;
			end
			S_REST: begin
				if (rem_q == '0) begin
					status_d = ST_DONE;
					state_d = S_OUT;
				end else if (fh_q < NIL) begin
					aidx_d = fh_q;
					n_re = 1'b1;
					n_ra = IW'(fh_q);
					state_d = S_AREAD;
				end else if (used_q < NIL) begin
					aidx_d = used_q;
					used_d = used_q + NW'(1);
					l_re = 1'b1;
					l_ra = {side_q, price_q};
					state_d = S_PLVL;
				end else begin
					status_d = ST_POOLFULL;
					state_d = S_OUT;
				end
			end
			S_AREAD: begin
				fh_d = (nrd.next < NIL) ? nrd.next : NIL;
				l_re = 1'b1;
				l_ra = {side_q, price_q};
				state_d = S_PLVL;
			end
			S_PLVL: begin
				n_we = 1'b1;
				n_wa = IW'(aidx_q);
				n_wd = '{oid: id_q, qty: rem_q, next: NIL, prev: (tv ? lrd.tail : NIL),
					side: side_q, price: price_q};
				live_d[IW'(aidx_q)] = 1'b1;
				l_we = 1'b1;
				l_wa = {side_q, price_q};
				l_wd.head = tv ? lrd.head : aidx_q;
				l_wd.tail = aidx_q;
				bmp_d[side_q][price_q] = 1'b1;
				if (side_q == SIDE_BUY) begin
					if (!bid_ok_q || price_q > bbid_q) begin
						bbid_d = price_q;
					end
					bid_ok_d = 1'b1;
				end else begin
					if (!ask_ok_q || price_q < bask_q) begin
						bask_d = price_q;
					end
					ask_ok_d = 1'b1;
				end
				status_d = ST_RESTED;
				if (tv) begin
					n_re = 1'b1;
					n_ra = IW'(lrd.tail);
					state_d = S_PTW;
				end else begin
					state_d = S_OUT;
				end
			end
			S_PTW: begin
				n_we = 1'b1;
				n_wa = IW'(lrd.tail);
				n_wd.next = aidx_q;
				state_d = S_OUT;
			end
			S_CRD: begin
				n_re = 1'b1;
				n_ra = ci_q;
				state_d = S_CCMP;
			end
			S_CCMP: begin
				if (live_q[ci_q] && nrd.oid == id_q) begin
					pv_d = nrd.prev;
					nx_d = nrd.next;
					cside_d = nrd.side;
					cprice_d = nrd.price;
					l_re = 1'b1;
					l_ra = {nrd.side, nrd.price};
					state_d = S_CLVL;
				end else if (ci_q == IW'(MAX_ORDERS - 1)) begin
					state_d = S_OUT;
				end else begin
					ci_d = ci_q + IW'(1);
					state_d = S_CRD;
				end
			end
			S_CLVL: begin
				status_d = ST_CANCELLED;
				l_we = 1'b1;
				l_wa = {cside_q, cprice_q};
				l_wd.head = (pv_q < NIL) ? lrd.head : nx_q;
				l_wd.tail = (nx_q < NIL) ? lrd.tail : pv_q;
				n_we = 1'b1;
				n_wa = ci_q;
				n_wd.next = fh_q;
				fh_d = NW'(ci_q);
				live_d[ci_q] = 1'b0;
				if (pv_q < NIL) begin
					n_re = 1'b1;
					n_ra = IW'(pv_q);
					state_d = S_CPW;
				end else if (nx_q < NIL) begin
					n_re = 1'b1;
					n_ra = IW'(nx_q);
					state_d = S_CNW;
				end else begin
					bmp_d[cside_q][cprice_q] = 1'b0;
					scside_d = cside_q;
					sc_d = (cside_q == SIDE_BUY) ? CW'(NCH - 1) : '0;
					scret_d = S_OUT;
					state_d = S_SCAN;
				end
			end
			S_CPW: begin
				n_we = 1'b1;
				n_wa = IW'(pv_q);
				n_wd.next = nx_q;
				if (nx_q < NIL) begin
					n_re = 1'b1;
					n_ra = IW'(nx_q);
					state_d = S_CNW;
				end else begin
					state_d = S_OUT;
				end
			end
			S_CNW: begin
				n_we = 1'b1;
				n_wa = IW'(nx_q);
				n_wd.prev = pv_q;
				state_d = S_OUT;
			end
			S_SCAN: begin
				if (chunk != '0) begin
					if (scside_q == SIDE_SELL) begin
						bask_d = PW'({sc_q, lo_bit});
						ask_ok_d = 1'b1;
					end else begin
						bbid_d = PW'({sc_q, hi_bit});
						bid_ok_d = 1'b1;
					end
					state_d = scret_q;
				end else if (scside_q == SIDE_SELL) begin
					if (sc_q == CW'(NCH - 1)) begin
						ask_ok_d = 1'b0;
						state_d = scret_q;
					end else begin
						sc_d = sc_q + CW'(1);
					end
				end else begin
					if (sc_q == '0) begin
						bid_ok_d = 1'b0;
						state_d = scret_q;
					end else begin
						sc_d = sc_q - CW'(1);
					end
				end
			end
			S_OUT: begin
				if (n_q == '0) begin
					if (slot_free) begin
						out_ld = 1'b1;
						res_d = '{is_trade: 1'b0, resting_order_id: '0, aggressor_order_id: id_q,
							trade_price_tick: '0, fill_quantity: '0, last: 1'b1,
							status: status_q,
							best_bid_tick: (bid_ok_q ? 8'(bbid_q) : 8'd0), bid_present: bid_ok_q,
							best_ask_tick: (ask_ok_q ? 8'(bask_q) : 8'd0), ask_present: ask_ok_q};
						state_d = S_IDLE;
					end
				end else begin
					r_re = 1'b1;
					r_ra = '0;
					oj_d = '0;
					state_d = S_OLOAD;
				end
			end
			S_OLOAD: begin
				if (slot_free) begin
					out_ld = 1'b1;
					res_d = '{is_trade: 1'b1, resting_order_id: rrd.rid, aggressor_order_id: id_q,
						trade_price_tick: rrd.price, fill_quantity: rrd.fill,
						last: (oj_q == n_q - 7'd1),
						status: ((oj_q == n_q - 7'd1) ? status_q : ST_NONE),
						best_bid_tick: (bid_ok_q ? 8'(bbid_q) : 8'd0), bid_present: bid_ok_q,
						best_ask_tick: (ask_ok_q ? 8'(bask_q) : 8'd0), ask_present: ask_ok_q};
					if (oj_q == n_q - 7'd1) begin
						state_d = S_IDLE;
					end else begin
						oj_d = oj_q + 7'd1;
						r_re = 1'b1;
						r_ra = RAW'(oj_q + 7'd1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (n_we) begin
			nmem[n_wa] <= n_wd;
		end
		if (n_re) begin
			nrd <= nmem[n_ra];
		end
		if (l_we) begin
			lmem[l_wa] <= l_wd;
		end
		if (l_re) begin
			lrd <= lmem[l_ra];
		end
		if (r_we) begin
			rmem[r_wa] <= r_wd;
		end
		if (r_re) begin
			rrd <= rmem[r_ra];
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
		rem_q <= rem_d;
		side_q <= side_d;
		price_q <= price_d;
		lvl_q <= lvl_d;
		oj_q <= oj_d;
		status_q <= status_d;
		aidx_q <= aidx_d;
		nx_q <= nx_d;
		pv_q <= pv_d;
		ci_q <= ci_d;
		cside_q <= cside_d;
		cprice_q <= cprice_d;
		sc_q <= sc_d;
		scside_q <= scside_d;
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scret_q <= S_IDLE;
			n_q <= '0;
			bbid_q <= '0;
			bask_q <= '0;
			bid_ok_q <= 1'b0;
			ask_ok_q <= 1'b0;
			fh_q <= NIL;
			used_q <= '0;
			live_q <= '0;
			bmp_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scret_q <= scret_d;
			n_q <= n_d;
			bbid_q <= bbid_d;
			bask_q <= bask_d;
			bid_ok_q <= bid_ok_d;
			ask_ok_q <= ask_ok_d;
			fh_q <= fh_d;
			used_q <= used_d;
			live_q <= live_d;
			bmp_q <= bmp_d;
			res_valid_q <= out_ld || (res_valid_q && !res_ready);
		end
	end

	assign ord_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 7'(RCAP))
		else $error("trade count above buffer depth");

	a_pool_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= NIL)
		else $error("pool use count beyond pool");

	a_best_bid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && bid_ok_q) |-> bmp_q[SIDE_BUY][bbid_q])
		else $error("best bid on an empty level");

	a_best_ask: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && ask_ok_q) |-> bmp_q[SIDE_SELL][bask_q])
		else $error("best ask on an empty level");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ord_valid && ord_ready) |=> (state_q != S_IDLE))
		else $error("accepted word left no step running");

endmodule
